// ===== src/svm_pkg.sv =====
// Shared types, constants and address helpers for the stack VM execute block.
// No dependencies; every other file in src except svm_ram imports this package.
`default_nettype none
package svm_pkg;

   localparam int MEM_WORDS  = 4096;
   localparam int TEXT_WORDS = 65536;
   localparam int MEM_AW     = $clog2(MEM_WORDS);
   localparam int PC_W       = $clog2(TEXT_WORDS);
   localparam int MEM_BYTES  = 4 * MEM_WORDS;
   localparam int SP_W       = 15;

   localparam logic signed [35:0] MEM_BYTES_S = 36'(MEM_BYTES);

   localparam logic [SP_W-1:0] STACK_TOP_RESET = SP_W'(16384);
   localparam logic [15:0]     ENTRY_PC_RESET  = 16'd0;

   // register map, indexed by paddr[2]
   localparam logic CSR_STACK_TOP = 1'b0;
   localparam logic CSR_ENTRY_PC  = 1'b1;

   // opcodes
   localparam logic [5:0] OP_LEA  = 6'd0;
   localparam logic [5:0] OP_IMM  = 6'd1;
   localparam logic [5:0] OP_JMP  = 6'd2;
   localparam logic [5:0] OP_CALL = 6'd3;
   localparam logic [5:0] OP_JZ   = 6'd4;
   localparam logic [5:0] OP_JNZ  = 6'd5;
   localparam logic [5:0] OP_ENT  = 6'd6;
   localparam logic [5:0] OP_ADJ  = 6'd7;
   localparam logic [5:0] OP_LEV  = 6'd8;
   localparam logic [5:0] OP_LC   = 6'd9;
   localparam logic [5:0] OP_LI   = 6'd10;
   localparam logic [5:0] OP_SC   = 6'd11;
   localparam logic [5:0] OP_SI   = 6'd12;
   localparam logic [5:0] OP_PUSH = 6'd13;
   localparam logic [5:0] OP_OR   = 6'd14;
   localparam logic [5:0] OP_XOR  = 6'd15;
   localparam logic [5:0] OP_AND  = 6'd16;
   localparam logic [5:0] OP_EQ   = 6'd17;
   localparam logic [5:0] OP_NE   = 6'd18;
   localparam logic [5:0] OP_LT   = 6'd19;
   localparam logic [5:0] OP_GT   = 6'd20;
   localparam logic [5:0] OP_LE   = 6'd21;
   localparam logic [5:0] OP_GE   = 6'd22;
   localparam logic [5:0] OP_SHL  = 6'd23;
   localparam logic [5:0] OP_SHR  = 6'd24;
   localparam logic [5:0] OP_ADD  = 6'd25;
   localparam logic [5:0] OP_SUB  = 6'd26;
   localparam logic [5:0] OP_MUL  = 6'd27;
   localparam logic [5:0] OP_DIV  = 6'd28;
   localparam logic [5:0] OP_MOD  = 6'd29;
   localparam logic [5:0] OP_EXIT = 6'd37;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EXIT  = 3'd1;
   localparam logic [2:0] ST_UNSUP = 3'd2;
   localparam logic [2:0] ST_DIVZ  = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   typedef struct packed {
      logic load_item;
      logic rd1;
      logic cap1;
      logic cap2;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_busy;
   } dp_status_type;

   function automatic logic [MEM_AW-1:0] word_idx(input logic [31:0] a);
      return a[MEM_AW+1:2];
   endfunction

   function automatic logic in_mem(input logic signed [35:0] a);
      return (a >= 36'sd0) && (a < MEM_BYTES_S);
   endfunction

   function automatic logic sp_ok(input logic signed [35:0] a);
      return (a >= 36'sd0) && (a <= MEM_BYTES_S);
   endfunction

   function automatic logic [31:0] sext8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

endpackage
`default_nettype wire

// ===== src/svm_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module svm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ===== src/svm_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on svm_pkg (imported for house consistency of types).
`default_nettype none
module svm_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [31:0]      quotient,
   output logic [31:0]      remainder
);
   import svm_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      shifted  = {rem_ff, quo_ff[31]};
      diff     = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in   = dividend[31] ? (32'd0 - dividend) : dividend;
         dsr_in   = divisor[31] ? (32'd0 - divisor) : divisor;
         rem_in   = 32'd0;
         neg_q_in = dividend[31] ^ divisor[31];
         neg_r_in = dividend[31];
         cnt_in   = 6'd32;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in  = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign busy      = busy_ff;
   assign quotient  = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
   assign remainder = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
endmodule
`default_nettype wire

// ===== src/svm_ctrl.sv =====
// Sequencer for the stack VM: item accept, memory read phases, divide wait,
// write-back and the result register handshake. Depends on svm_pkg.
`default_nettype none
module svm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output svm_pkg::ctrl_cmd_type       cmd,
   input  wire svm_pkg::dp_status_type status
);
   import svm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_CAP1  = 3'd2;
   localparam logic [2:0] S_CAP2  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_WB    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load_item = accept;
            if (accept) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.rd1  = 1'b1;
            state_in = S_CAP1;
         end
         S_CAP1: begin
            cmd.cap1 = 1'b1;
            state_in = S_CAP2;
         end
         S_CAP2: begin
            cmd.cap2      = 1'b1;
            cmd.div_start = status.is_div;
            state_in      = status.is_div ? S_DIV : S_WB;
         end
         S_DIV: begin
            if (!status.div_busy) state_in = S_WB;
         end
         S_WB: begin
            // hold until the result register is free
            cmd.commit = out_free;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_issues: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_ISSUE)
      else $error("accepted item did not start a read phase");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_WB)
      else $error("result raised outside write-back");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CAP2 && status.is_div) |=> status.div_busy)
      else $error("divider did not start");
endmodule
`default_nettype wire

// ===== src/svm_dpath.sv =====
// Datapath for the stack VM: architectural registers, data memory, divider,
// instruction evaluation and the result register. Depends on svm_pkg,
// svm_ram and svm_div.
`default_nettype none
module svm_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire svm_pkg::ctrl_cmd_type cmd,
   output svm_pkg::dp_status_type     status,
   input  wire logic                  cfg_wr_sp,
   input  wire logic                  cfg_wr_pc,
   input  wire logic [31:0]           cfg_data,
   input  wire logic [5:0]            req_func,
   input  wire logic signed [31:0]    req_imm,
   output logic [15:0]                rsp_next_pc,
   output logic signed [31:0]         rsp_acc,
   output logic [2:0]                 rsp_status,
   output logic signed [31:0]         rsp_exit_code
);
   import svm_pkg::*;

   logic [5:0]      func_ff;
   logic [31:0]     imm_ff;
   logic [31:0]     acc_ff, acc_in;
   logic [SP_W-1:0] sp_ff, sp_in, bp_ff, bp_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            halted_ff, halted_in;
   logic [31:0]     w1_ff, w2_ff;

   logic [15:0] out_pc_ff;
   logic [31:0] out_acc_ff, out_xc_ff;
   logic [2:0]  out_st_ff;

   logic              ram_we;
   logic [MEM_AW-1:0] ram_addr, addr1, addr2;
   logic [31:0]       ram_wdata, ram_rdata;

   logic [31:0] quot, rem;
   logic        div_busy;

   // evaluation results
   logic [31:0]     nacc, wv, xcode;
   logic [SP_W-1:0] nsp, nbp;
   logic [PC_W-1:0] npc, pc1, pc2;
   logic [2:0]      st;
   logic            wen;
   logic [MEM_AW-1:0] wa;

   logic signed [35:0] sp_s, bp_s, imm4, spm4, t_ent, t_adj, acc_s, w1_s;
   logic signed [31:0] sa, sb;
   logic [7:0]         lbyte;
   logic [31:0]        merged;
   logic               take;

   assign status.is_div   = !halted_ff && (func_ff == OP_DIV || func_ff == OP_MOD);
   assign status.div_busy = div_busy;

   svm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   svm_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(w1_ff), .divisor(acc_ff),
      .busy(div_busy), .quotient(quot), .remainder(rem)
   );

   // first read: stack top, frame or accumulator address
   always_comb begin
      if (halted_ff) addr1 = word_idx(32'(sp_ff));
      else if (func_ff == OP_LEV) addr1 = word_idx(32'(bp_ff));
      else if (func_ff == OP_LC || func_ff == OP_LI) addr1 = word_idx(acc_ff);
      else addr1 = word_idx(32'(sp_ff));
   end

   // second read: return address for leave, store target for stores
   assign addr2 = (func_ff == OP_LEV) ? word_idx(32'(bp_ff) + 32'd4) : word_idx(ram_rdata);

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = addr1;
      ram_wdata = wv;
      if (cmd.commit) begin
         ram_we   = wen && (st == ST_OK);
         ram_addr = wa;
      end else if (cmd.cap1) begin
         ram_addr = addr2;
      end
   end

   always_comb begin
      sp_s  = $signed({21'd0, sp_ff});
      bp_s  = $signed({21'd0, bp_ff});
      imm4  = $signed({{2{imm_ff[31]}}, imm_ff, 2'b00});
      spm4  = sp_s - 36'sd4;
      t_ent = spm4 - imm4;
      t_adj = sp_s + imm4;
      acc_s = $signed({4'd0, acc_ff});
      w1_s  = $signed({4'd0, w1_ff});
      sa    = $signed(w1_ff);
      sb    = $signed(acc_ff);
      pc1   = pc_ff + PC_W'(1);
      pc2   = pc_ff + PC_W'(2);
      lbyte = 8'(w1_ff >> {acc_ff[1:0], 3'b000});
      merged = (w2_ff & ~(32'h0000_00ff << {w1_ff[1:0], 3'b000}))
             | ({24'd0, acc_ff[7:0]} << {w1_ff[1:0], 3'b000});
      take  = (func_ff == OP_JMP) || (func_ff == OP_JZ && acc_ff == 32'd0)
           || (func_ff == OP_JNZ && acc_ff != 32'd0);

      nacc  = acc_ff;
      nsp   = sp_ff;
      nbp   = bp_ff;
      npc   = pc1;
      st    = ST_OK;
      wen   = 1'b0;
      wa    = word_idx(spm4[31:0]);
      wv    = acc_ff;
      xcode = 32'd0;

      if (halted_ff) begin
         st    = ST_EXIT;
         xcode = in_mem(sp_s) ? w1_ff : 32'd0;
      end else begin
         case (func_ff)
            OP_LEA: begin
               nacc = 32'(bp_ff) + {imm_ff[29:0], 2'b00};
               npc  = pc2;
            end
            OP_IMM: begin
               nacc = imm_ff;
               npc  = pc2;
            end
            OP_JMP, OP_JZ, OP_JNZ: begin
               if (!take) npc = pc2;
               else if (imm_ff[31:PC_W] == '0) npc = imm_ff[PC_W-1:0];
               else st = ST_RANGE;
            end
            OP_CALL: begin
               if (!in_mem(spm4) || imm_ff[31:PC_W] != '0) st = ST_RANGE;
               wen = 1'b1;
               wv  = 32'(pc2);
               nsp = spm4[SP_W-1:0];
               npc = imm_ff[PC_W-1:0];
            end
            OP_ENT: begin
               if (!in_mem(spm4) || !sp_ok(t_ent)) st = ST_RANGE;
               wen = 1'b1;
               wv  = 32'(bp_ff);
               nbp = spm4[SP_W-1:0];
               nsp = t_ent[SP_W-1:0];
               npc = pc2;
            end
            OP_ADJ: begin
               if (!sp_ok(t_adj)) st = ST_RANGE;
               nsp = t_adj[SP_W-1:0];
               npc = pc2;
            end
            OP_LEV: begin
               if (!in_mem(bp_s) || !in_mem(bp_s + 36'sd4) || !sp_ok(w1_s)
                   || w2_ff[31:PC_W] != '0) st = ST_RANGE;
               nbp = w1_ff[SP_W-1:0];
               npc = w2_ff[PC_W-1:0];
               nsp = SP_W'(bp_ff + SP_W'(8));
            end
            OP_LC, OP_LI: begin
               if (!in_mem(acc_s)) st = ST_RANGE;
               nacc = (func_ff == OP_LC) ? sext8(lbyte) : w1_ff;
            end
            OP_SC, OP_SI: begin
               if (!in_mem(sp_s) || !in_mem(w1_s)) st = ST_RANGE;
               wen  = 1'b1;
               wa   = word_idx(w1_ff);
               wv   = (func_ff == OP_SC) ? merged : acc_ff;
               nacc = (func_ff == OP_SC) ? sext8(acc_ff[7:0]) : acc_ff;
               nsp  = sp_ff + SP_W'(4);
            end
            OP_PUSH: begin
               if (!in_mem(spm4)) st = ST_RANGE;
               wen = 1'b1;
               nsp = spm4[SP_W-1:0];
            end
            OP_EXIT: begin
               if (!in_mem(sp_s)) st = ST_RANGE;
               else begin
                  st    = ST_EXIT;
                  xcode = w1_ff;
               end
            end
            OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE,
            OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
               nsp = sp_ff + SP_W'(4);
               if (!in_mem(sp_s)) st = ST_RANGE;
               else if ((func_ff == OP_DIV || func_ff == OP_MOD) && acc_ff == 32'd0)
                  st = ST_DIVZ;
               case (func_ff)
                  OP_OR:   nacc = w1_ff | acc_ff;
                  OP_XOR:  nacc = w1_ff ^ acc_ff;
                  OP_AND:  nacc = w1_ff & acc_ff;
                  OP_EQ:   nacc = 32'(sa == sb);
                  OP_NE:   nacc = 32'(sa != sb);
                  OP_LT:   nacc = 32'(sa < sb);
                  OP_GT:   nacc = 32'(sa > sb);
                  OP_LE:   nacc = 32'(sa <= sb);
                  OP_GE:   nacc = 32'(sa >= sb);
                  OP_SHL:  nacc = w1_ff << acc_ff[4:0];
                  OP_SHR:  nacc = 32'(sa >>> acc_ff[4:0]);
                  OP_ADD:  nacc = w1_ff + acc_ff;
                  OP_SUB:  nacc = w1_ff - acc_ff;
                  OP_MUL:  nacc = 32'(w1_ff * acc_ff);
                  OP_DIV:  nacc = quot;
                  default: nacc = rem;
               endcase
            end
            default: st = ST_UNSUP;
         endcase
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      sp_in     = sp_ff;
      bp_in     = bp_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      if (cmd.commit) begin
         if (st == ST_OK) begin
            acc_in = nacc;
            sp_in  = nsp;
            bp_in  = nbp;
            pc_in  = npc;
         end else if (st == ST_EXIT) begin
            halted_in = 1'b1;
         end
      end
      if (cfg_wr_sp) begin
         sp_in = cfg_data[SP_W-1:0];
         bp_in = cfg_data[SP_W-1:0];
      end
      if (cfg_wr_pc) begin
         pc_in     = cfg_data[PC_W-1:0];
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 32'd0;
         sp_ff     <= STACK_TOP_RESET;
         bp_ff     <= STACK_TOP_RESET;
         pc_ff     <= ENTRY_PC_RESET[PC_W-1:0];
         halted_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         sp_ff     <= sp_in;
         bp_ff     <= bp_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
      end
      if (cmd.load_item) begin
         func_ff <= req_func;
         imm_ff  <= req_imm;
      end
      if (cmd.cap1) w1_ff <= ram_rdata;
      if (cmd.cap2) w2_ff <= ram_rdata;
      if (cmd.commit) begin
         out_pc_ff  <= 16'((st == ST_OK) ? npc : pc_ff);
         out_acc_ff <= (st == ST_OK) ? nacc : acc_ff;
         out_st_ff  <= st;
         out_xc_ff  <= xcode;
      end
   end

   assign rsp_next_pc   = out_pc_ff;
   assign rsp_acc       = out_acc_ff;
   assign rsp_status    = out_st_ff;
   assign rsp_exit_code = out_xc_ff;

   // commits of a fault must not reach memory
   a_no_write_on_fault: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && st != ST_OK) |-> !ram_we)
      else $error("memory written on a faulting instruction");
endmodule
`default_nettype wire

// ===== src/stack_vm_instruction_execute_top.sv =====
// Top level of the stack VM execute block: APB register file and the
// controller/datapath pair. Depends on svm_pkg, svm_ctrl and svm_dpath.
//
// Each transfer on the req channel is one VM instruction (opcode plus operand
// word); each produces exactly one transfer on the rsp channel with the next
// fetch address, accumulator, status and exit code. An instruction passes
// through the core in steps from accept to result (issue a read, capture the
// first word, capture the second word, write back); DIV and MOD also wait
// on the bit-serial divider before write-back. The single data memory port
// sets this order: one read per cycle, and the write lands in write-back.
// A new instruction is taken as soon as the core returns to idle, even
// while the previous result still waits on rsp_stall; write-back holds
// only when that result register is still occupied. Configuration
// registers: stack_top at byte 0 (loads stack and frame pointers), entry_pc
// at byte 4 (loads the program counter and leaves the halted state). Write
// them only while no instruction is in flight.
`default_nettype none
module stack_vm_instruction_execute_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [5:0]         req_func,
   input  wire logic signed [31:0] req_imm,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [15:0]             rsp_next_pc,
   output logic signed [31:0]      rsp_acc,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_exit_code,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import svm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic [SP_W-1:0] stack_top_ff, stack_top_in;
   logic [15:0]     entry_pc_ff, entry_pc_in;
   logic            csr_wr;
   logic            wr_sp, wr_pc;

   // APB: zero-wait, write completes in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_sp      = csr_wr && (csr_paddr[2] == CSR_STACK_TOP);
   assign wr_pc      = csr_wr && (csr_paddr[2] == CSR_ENTRY_PC);

   always_comb begin
      stack_top_in = wr_sp ? csr_pwdata[SP_W-1:0] : stack_top_ff;
      entry_pc_in  = wr_pc ? csr_pwdata[15:0] : entry_pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_top_ff <= STACK_TOP_RESET;
         entry_pc_ff  <= ENTRY_PC_RESET;
      end else begin
         stack_top_ff <= stack_top_in;
         entry_pc_ff  <= entry_pc_in;
      end
   end

   // read back the register selected by the address
   assign csr_prdata = (csr_paddr[2] == CSR_ENTRY_PC) ? 32'(entry_pc_ff) : 32'(stack_top_ff);

   svm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .status(status)
   );

   svm_dpath u_dpath (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .cfg_wr_sp(wr_sp), .cfg_wr_pc(wr_pc), .cfg_data(csr_pwdata),
      .req_func(req_func), .req_imm(req_imm),
      .rsp_next_pc(rsp_next_pc), .rsp_acc(rsp_acc),
      .rsp_status(rsp_status), .rsp_exit_code(rsp_exit_code)
   );
endmodule
`default_nettype wire
